[rtl/core/fmtdec_pkg.sv]
package fmtdec_pkg;

	localparam int CHAR_W     = 8;
	localparam int WORD_W     = 32;
	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 10;
	localparam int CNT_W      = $clog2(MAX_DIGITS);

	localparam logic [WORD_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
	localparam int                RECIP_SH = 35;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
	localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [WORD_W-1:0]  quo;
		logic [DIGIT_W-1:0] rem;
	} div_res_t;

endpackage

[rtl/core/fmtdec_div10.sv]
module fmtdec_div10 (
	input  logic [fmtdec_pkg::WORD_W-1:0] mag,
	output fmtdec_pkg::div_res_t          res
);
	import fmtdec_pkg::*;

	logic [2*WORD_W-1:0] prod;
	logic [WORD_W-1:0]   quo;
	logic [WORD_W-1:0]   back;
	logic [WORD_W-1:0]   diff;

	// reciprocal multiply, then correct the remainder from the quotient
	assign prod = {{WORD_W{1'b0}}, mag} * {{WORD_W{1'b0}}, RECIP_10};
	assign quo  = WORD_W'(prod[2*WORD_W-1:RECIP_SH]);
	assign back = (quo << 3) + (quo << 1);
	assign diff = mag - back;

	assign res.quo = quo;
	assign res.rem = diff[DIGIT_W-1:0];

endmodule

[rtl/core/format_byte_stream_decimal_print.sv]
// Format byte printer. Each accepted transaction carries one format byte and a signed
// argument; output transactions carry one character each, a last flag on the final
// character of the transaction, and the running character count. A plain byte, or the
// specifier of a "%%" escape, is emitted as one character. A "%d" specifier first emits
// '-' for a negative argument, then produces one digit per step in the single divide-by-ten
// unit (a reciprocal multiply), up to ten digits, then emits the digits most significant
// first, waiting while the output is stalled. The input stalls until the block is
// idle and its output register is free.
module format_byte_stream_decimal_print (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fmtdec_pkg::CHAR_W-1:0]     format_char,
	input  logic signed [fmtdec_pkg::WORD_W-1:0] argument,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [fmtdec_pkg::CHAR_W-1:0]     out_char,
	output logic                              last,
	output logic [fmtdec_pkg::WORD_W-1:0]     emitted_total
);
	import fmtdec_pkg::*;

	state_t              state_q, state_d;
	logic                esc_q;
	logic [WORD_W-1:0]   count_q;
	logic [WORD_W-1:0]   mag_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIGIT_W-1:0]  digits_q [MAX_DIGITS];
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                last_q;
	logic [WORD_W-1:0]   total_q;

	logic                slot_free;
	logic                accept;
	logic                is_pct;
	logic                emit_now;
	logic                start_dec;
	logic                div_done;
	logic                emit_fire;
	logic                load_out;
	logic [CHAR_W-1:0]   load_char;
	logic                load_last;
	logic [WORD_W-1:0]   arg_u;
	div_res_t            div_res;

	fmtdec_div10 u_div (
		.mag (mag_q),
		.res (div_res)
	);

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE) || !slot_free;
	assign accept    = in_valid && !in_stall;
	assign is_pct    = format_char == CH_PCT;
	assign arg_u     = WORD_W'(argument);
	assign emit_now  = accept && (esc_q ? is_pct : !is_pct);
	assign start_dec = accept && esc_q && (format_char == CH_D);
	assign div_done  = (div_res.quo == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1));
	assign emit_fire = (state_q == ST_EMIT) && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_dec) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_fire && (cnt_q == '0)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		load_out  = 1'b0;
		load_char = format_char;
		load_last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (emit_now) begin
					load_out = 1'b1;
				end else if (start_dec && argument[WORD_W-1]) begin
					load_out  = 1'b1;
					load_char = CH_MINUS;
					load_last = 1'b0;
				end
			end
			ST_EMIT: begin
				load_out  = emit_fire;
				load_char = CH_ZERO + CHAR_W'(digits_q[cnt_q]);
				load_last = cnt_q == '0;
			end
			ST_DIV: begin
				load_out = 1'b0;
			end
			default: load_out = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			esc_q       <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				esc_q <= !esc_q && is_pct;
			end
			if (load_out) begin
				count_q     <= count_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (start_dec) begin
				cnt_q <= '0;
			end else if ((state_q == ST_DIV) && !div_done) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (emit_fire && (cnt_q != '0)) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_dec) begin
			mag_q <= argument[WORD_W-1] ? ('0 - arg_u) : arg_u;
		end else if (state_q == ST_DIV) begin
			mag_q           <= div_res.quo;
			digits_q[cnt_q] <= div_res.rem;
		end
		if (load_out) begin
			out_char_q <= load_char;
			last_q     <= load_last;
			total_q    <= count_q + 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_char      = out_char_q;
	assign last          = last_q;
	assign emitted_total = total_q;

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && slot_free |=> out_valid)
		else $error("digit emit did not load output");

	a_div_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && out_valid |-> !last)
		else $error("last flag set before digits were emitted");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_DIGITS - 1))
		else $error("digit index out of range");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		start_dec |=> in_stall)
		else $error("input taken during decimal conversion");

endmodule
